[rtl/rgbhsv_pkg.sv]
// shared types and constants for the rgb to hsv color classifier
package rgbhsv_pkg;

   // one pixel in, one hsv triple and class out
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_pixel_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic [2:0] color_class;
   } rsp_hsv_type;

   // color class codes
   localparam logic [2:0] CLS_GRAY   = 3'd0;
   localparam logic [2:0] CLS_BLACK  = 3'd1;
   localparam logic [2:0] CLS_BLUE   = 3'd2;
   localparam logic [2:0] CLS_GREEN  = 3'd3;
   localparam logic [2:0] CLS_RED    = 3'd4;
   localparam logic [2:0] CLS_YELLOW = 3'd5;
   localparam logic [2:0] CLS_NONE   = 3'd6;

   // hue sector bases and span
   localparam logic [7:0] HUE_BASE_RED   = 8'd0;
   localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
   localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
   localparam logic [7:0] HUE_SPAN       = 8'd43;

   // one quotient bit per divider stage
   localparam int DIV_STAGES = 8;

   // scale factors for the class compares
   localparam logic [16:0] DEG_FULL = 17'd360;
   localparam logic [14:0] PCT_FULL = 15'd100;

   // limits scaled by 255, degree side
   localparam logic [16:0] DEG_LIM_30  = 17'(30 * 255);
   localparam logic [16:0] DEG_LIM_65  = 17'(65 * 255);
   localparam logic [16:0] DEG_LIM_75  = 17'(75 * 255);
   localparam logic [16:0] DEG_LIM_150 = 17'(150 * 255);
   localparam logic [16:0] DEG_LIM_260 = 17'(260 * 255);
   localparam logic [16:0] DEG_LIM_300 = 17'(300 * 255);

   // limits scaled by 255, percent side
   localparam logic [14:0] PCT_LIM_10 = 15'(10 * 255);
   localparam logic [14:0] PCT_LIM_15 = 15'(15 * 255);
   localparam logic [14:0] PCT_LIM_17 = 15'(17 * 255);
   localparam logic [14:0] PCT_LIM_50 = 15'(50 * 255);

   // state carried through the divider stages
   typedef struct packed {
      logic [15:0] sat_rem;
      logic [7:0]  sat_quo;
      logic [13:0] hue_rem;
      logic [5:0]  hue_quo;
      logic [7:0]  max_val;
      logic [7:0]  span;
      logic        hue_neg;
      logic [7:0]  hue_base;
   } div_stage_type;

endpackage

[rtl/rgb_to_hsv_color_classifier_core.sv]
// rgb to hsv color classifier: pipelined max/min, dividers and class compare
// pipeline: input, prep, hsv and output stages around 8 restoring divider stages
// throughput: one pixel per clock, every stage takes a new transaction each cycle
// busy is held low: the receiver cannot stall, so the pipeline never holds
// reset: synchronous, active high, clears all valid bits; payload is not reset
module rgb_to_hsv_color_classifier_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  rgbhsv_pkg::req_pixel_type  req_pixel,
   output logic                       rsp_strobe,
   output rgbhsv_pkg::rsp_hsv_type    rsp_hsv
);
   import rgbhsv_pkg::*;

   // stage 0: input register
   logic          in_valid_ff;
   req_pixel_type in_pixel_ff;

   // stage 1: max, min, span, numerators
   logic          prep_valid_ff;
   div_stage_type prep_ff;
   div_stage_type prep_in;

   // stages 2..9: one quotient bit per stage for both dividers
   logic [DIV_STAGES-1:0] div_valid_ff;
   div_stage_type         div_ff [DIV_STAGES];
   div_stage_type         div_in [DIV_STAGES];
   div_stage_type         div_src [DIV_STAGES];

   // stage 10: final hsv
   logic       hsv_valid_ff;
   logic [7:0] hue_ff, sat_ff, val_ff;
   logic [7:0] hue_in, sat_in;

   // stage 11: class and output register
   logic        out_valid_ff;
   rsp_hsv_type out_ff;
   logic [2:0]  class_in;

   // no stall path anywhere in the pipe
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // stage 1 logic
   // ---------------------------------------------------------------
   logic [7:0] r_c, g_c, b_c, mx_c, mn_c, mag_c;
   logic [8:0] diff_c;

   always_comb begin
      r_c = in_pixel_ff.red;
      g_c = in_pixel_ff.green;
      b_c = in_pixel_ff.blue;
      mx_c = r_c;
      if (g_c > mx_c) mx_c = g_c;
      if (b_c > mx_c) mx_c = b_c;
      mn_c = r_c;
      if (g_c < mn_c) mn_c = g_c;
      if (b_c < mn_c) mn_c = b_c;

      // hue sector, ties resolve red first, then green
      if (mx_c == r_c) begin
         diff_c = {1'b0, g_c} - {1'b0, b_c};
         prep_in.hue_base = HUE_BASE_RED;
      end else if (mx_c == g_c) begin
         diff_c = {1'b0, b_c} - {1'b0, r_c};
         prep_in.hue_base = HUE_BASE_GREEN;
      end else begin
         diff_c = {1'b0, r_c} - {1'b0, g_c};
         prep_in.hue_base = HUE_BASE_BLUE;
      end
      prep_in.hue_neg = diff_c[8];
      // magnitude; truncation toward zero comes from dividing magnitudes
      mag_c = diff_c[8] ? 8'(-diff_c) : diff_c[7:0];

      prep_in.max_val = mx_c;
      prep_in.span    = mx_c - mn_c;
      // 255*span as shift and subtract
      prep_in.sat_rem = {prep_in.span, 8'd0} - {8'd0, prep_in.span};
      prep_in.sat_quo = '0;
      prep_in.hue_rem = 14'(mag_c) * 14'(HUE_SPAN);
      prep_in.hue_quo = '0;
   end

   // ---------------------------------------------------------------
   // divider stages: restoring, msb first
   // saturation quotient is at most 255 since span <= max
   // hue quotient is at most 43, so its upper bits never set
   // ---------------------------------------------------------------
   always_comb begin
      logic [15:0] sat_cmp;
      logic [13:0] hue_cmp;
      for (int i = 0; i < DIV_STAGES; i++) begin
         div_src[i] = (i == 0) ? prep_ff : div_ff[(i == 0) ? 0 : i - 1];
      end
      for (int i = 0; i < DIV_STAGES; i++) begin
         div_in[i] = div_src[i];
         sat_cmp = 16'(div_src[i].max_val) << (DIV_STAGES - 1 - i);
         if (div_src[i].sat_rem >= sat_cmp) begin
            div_in[i].sat_rem = div_src[i].sat_rem - sat_cmp;
            div_in[i].sat_quo = div_src[i].sat_quo | (8'd1 << (DIV_STAGES - 1 - i));
         end
         hue_cmp = 14'(div_src[i].span) << (DIV_STAGES - 1 - i);
         if ((DIV_STAGES - 1 - i) < 6 && div_src[i].hue_rem >= hue_cmp) begin
            div_in[i].hue_rem = div_src[i].hue_rem - hue_cmp;
            div_in[i].hue_quo = div_src[i].hue_quo | (6'd1 << (DIV_STAGES - 1 - i));
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 10 logic: sign, base, special cases
   // ---------------------------------------------------------------
   div_stage_type last_c;
   logic [7:0]    hue_off_c;

   always_comb begin
      last_c    = div_ff[DIV_STAGES-1];
      hue_off_c = last_c.hue_neg ? 8'(-{2'b00, last_c.hue_quo}) : {2'b00, last_c.hue_quo};
      // black pixel: divisor zero, force saturation to zero
      sat_in = (last_c.max_val == 8'd0) ? 8'd0 : last_c.sat_quo;
      // gray or black: no hue
      hue_in = (last_c.span == 8'd0) ? 8'd0 : last_c.hue_base + hue_off_c;
   end

   // ---------------------------------------------------------------
   // stage 11 logic: class compares, exact in integers
   // ---------------------------------------------------------------
   logic [16:0] deg_c;
   logic [14:0] s_pct_c, v_pct_c;

   always_comb begin
      deg_c   = 17'(hue_ff) * DEG_FULL;
      s_pct_c = 15'(sat_ff) * PCT_FULL;
      v_pct_c = 15'(val_ff) * PCT_FULL;
      if (s_pct_c < PCT_LIM_15 && v_pct_c > PCT_LIM_50) begin
         class_in = CLS_GRAY;
      end else if (s_pct_c < PCT_LIM_17 && v_pct_c < PCT_LIM_10) begin
         class_in = CLS_BLACK;
      end else if (deg_c >= DEG_LIM_150 && deg_c <= DEG_LIM_260) begin
         class_in = CLS_BLUE;
      end else if (deg_c >= DEG_LIM_75 && deg_c <= DEG_LIM_150) begin
         class_in = CLS_GREEN;
      end else if (deg_c >= DEG_LIM_300 || deg_c <= DEG_LIM_30) begin
         class_in = CLS_RED;
      end else if (deg_c >= DEG_LIM_30 && deg_c <= DEG_LIM_65) begin
         class_in = CLS_YELLOW;
      end else begin
         class_in = CLS_NONE;
      end
   end

   // ---------------------------------------------------------------
   // valid bits, cleared by reset
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prep_valid_ff <= 1'b0;
         div_valid_ff  <= '0;
         hsv_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= start && !busy;
         prep_valid_ff <= in_valid_ff;
         div_valid_ff  <= {div_valid_ff[DIV_STAGES-2:0], prep_valid_ff};
         hsv_valid_ff  <= div_valid_ff[DIV_STAGES-1];
         out_valid_ff  <= hsv_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // payload registers, no reset
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      in_pixel_ff <= req_pixel;
      prep_ff     <= prep_in;
      for (int i = 0; i < DIV_STAGES; i++) begin
         div_ff[i] <= div_in[i];
      end
      hue_ff <= hue_in;
      sat_ff <= sat_in;
      val_ff <= last_c.max_val;
      out_ff.hue         <= hue_ff;
      out_ff.saturation  <= sat_ff;
      out_ff.brightness  <= val_ff;
      out_ff.color_class <= class_in;
   end

   assign rsp_strobe = out_valid_ff;
   assign rsp_hsv    = out_ff;

`ifndef ASSERT_OFF
   // every accepted transaction comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##12 rsp_strobe)
      else $error("result strobe missing after fixed latency");

   // black pixel forces zero saturation and zero hue
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hsv.brightness == 8'd0) |->
      (rsp_hsv.saturation == 8'd0 && rsp_hsv.hue == 8'd0))
      else $error("black pixel with nonzero hue or saturation");

   // no saturation means no hue
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hsv.saturation == 8'd0) |-> (rsp_hsv.hue == 8'd0))
      else $error("hue set on unsaturated pixel");

   // class code stays within the defined set
   a_class: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_hsv.color_class <= CLS_NONE))
      else $error("undefined color class code");
`endif

endmodule

[tb/hsv_pixel_checker.sv]
// checker for the rgb to hsv classifier: predicts each pixel's hsv triple and class
`timescale 1ns / 100ps

module hsv_pixel_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  rgbhsv_pkg::req_pixel_type req_pixel,
   input  logic                      rsp_strobe,
   input  rgbhsv_pkg::rsp_hsv_type   rsp_hsv,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        results_checked
);
   import rgbhsv_pkg::*;

   typedef struct {
      req_pixel_type pixel;
      rsp_hsv_type   hsv;
   } pixel_expectation_type;

   pixel_expectation_type expected_hsv_q[$];
   int error_total = 0;
   int checked_total = 0;

   // degree and percent limits compared as cross products, no rounding
   function automatic logic [2:0] classify_hsv(int h, int s, int v);
      int deg;
      int s_pct;
      int v_pct;
      deg   = h * int'(DEG_FULL);
      s_pct = s * int'(PCT_FULL);
      v_pct = v * int'(PCT_FULL);
      if (s_pct < int'(PCT_LIM_15) && v_pct > int'(PCT_LIM_50)) return CLS_GRAY;
      if (s_pct < int'(PCT_LIM_17) && v_pct < int'(PCT_LIM_10)) return CLS_BLACK;
      if (deg >= int'(DEG_LIM_150) && deg <= int'(DEG_LIM_260)) return CLS_BLUE;
      if (deg >= int'(DEG_LIM_75) && deg <= int'(DEG_LIM_150)) return CLS_GREEN;
      if (deg >= int'(DEG_LIM_300) || deg <= int'(DEG_LIM_30)) return CLS_RED;
      if (deg >= int'(DEG_LIM_30) && deg <= int'(DEG_LIM_65)) return CLS_YELLOW;
      return CLS_NONE;
   endfunction

   function automatic rsp_hsv_type predict_hsv(req_pixel_type px);
      int r;
      int g;
      int b;
      int mx;
      int mn;
      int span;
      int sat;
      int t;
      rsp_hsv_type hsv;
      r = px.red;
      g = px.green;
      b = px.blue;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      hsv = '0;
      hsv.brightness = mx[7:0];
      if (mx != 0) begin
         span = mx - mn;
         sat = (255 * span) / mx;
         hsv.saturation = sat[7:0];
         if (sat != 0 && span != 0) begin
            // ties on the max go red, then green, then blue
            if (mx == r)
               t = int'(HUE_SPAN) * (g - b) / span;
            else if (mx == g)
               t = int'(HUE_BASE_GREEN) + int'(HUE_SPAN) * (b - r) / span;
            else
               t = int'(HUE_BASE_BLUE) + int'(HUE_SPAN) * (r - g) / span;
            hsv.hue = t[7:0];
         end
      end
      hsv.color_class = classify_hsv(hsv.hue, hsv.saturation, hsv.brightness);
      return hsv;
   endfunction

   always @(posedge clock) begin
      pixel_expectation_type exp_item;
      if (!reset) begin
         if (start && !busy) begin
            exp_item.pixel = req_pixel;
            exp_item.hsv   = predict_hsv(req_pixel);
            expected_hsv_q.push_back(exp_item);
         end
         if (rsp_strobe) begin
            if (expected_hsv_q.size() == 0) begin
               $error("unexpected hsv transaction: hue %0d sat %0d val %0d class %0d",
                      rsp_hsv.hue, rsp_hsv.saturation, rsp_hsv.brightness,
                      rsp_hsv.color_class);
               error_total++;
            end else begin
               exp_item = expected_hsv_q.pop_front();
               checked_total++;
               if (rsp_hsv.hue !== exp_item.hsv.hue) begin
                  $error("hue mismatch for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                         exp_item.pixel.red, exp_item.pixel.green, exp_item.pixel.blue,
                         exp_item.hsv.hue, rsp_hsv.hue);
                  error_total++;
               end
               if (rsp_hsv.saturation !== exp_item.hsv.saturation) begin
                  $error("saturation mismatch for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                         exp_item.pixel.red, exp_item.pixel.green, exp_item.pixel.blue,
                         exp_item.hsv.saturation, rsp_hsv.saturation);
                  error_total++;
               end
               if (rsp_hsv.brightness !== exp_item.hsv.brightness) begin
                  $error("brightness mismatch for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                         exp_item.pixel.red, exp_item.pixel.green, exp_item.pixel.blue,
                         exp_item.hsv.brightness, rsp_hsv.brightness);
                  error_total++;
               end
               if (rsp_hsv.color_class !== exp_item.hsv.color_class) begin
                  $error("color_class mismatch for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                         exp_item.pixel.red, exp_item.pixel.green, exp_item.pixel.blue,
                         exp_item.hsv.color_class, rsp_hsv.color_class);
                  error_total++;
               end
            end
         end
      end
      mismatch_count  <= error_total;
      pending_count   <= expected_hsv_q.size();
      results_checked <= checked_total;
   end

endmodule

[tb/rgb_to_hsv_color_classifier_core_tb.sv]
// testbench top for the rgb to hsv color classifier: pixel stimulus and verdict
`timescale 1ns / 100ps

module rgb_to_hsv_color_classifier_core_tb;
   import rgbhsv_pkg::*;

   // number of random pixels after the directed corners
   localparam int RANDOM_PIXELS = 1530;
   // final stretch of the random part is sent back to back
   localparam int QUIET_TAIL = 200;
   // pipeline is 12 deep, give it some margin when draining
   localparam int DRAIN_CYCLES = 20;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_pixel_type req_pixel;
   logic          rsp_strobe;
   rsp_hsv_type   rsp_hsv;

   int mismatch_count;
   int pending_count;
   int results_checked;
   int pixels_sent;

   rgb_to_hsv_color_classifier_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_pixel  (req_pixel),
      .rsp_strobe (rsp_strobe),
      .rsp_hsv    (rsp_hsv)
   );

   hsv_pixel_checker hsv_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pixel       (req_pixel),
      .rsp_strobe      (rsp_strobe),
      .rsp_hsv         (rsp_hsv),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the pipeline hangs or drops a transaction
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // present one pixel and hold it until the block takes it;
   // start stays high so back-to-back calls stream one pixel per clock
   task automatic drive_pixel(req_pixel_type px);
      start     <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixels_sent++;
   endtask

   // drop start for a burst of idle cycles
   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // lower start and wait until every expected transaction has come back;
   // it waits on the clock first so the checker has seen the last accepted pixel
   task automatic wait_pipeline_empty();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] clamp_channel(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   // random pixels biased toward the interesting regions of the hsv space
   function automatic req_pixel_type random_pixel();
      req_pixel_type px;
      int base;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] mid;
      case ($urandom_range(0, 5))
         0, 1: begin
            // anything at all, toggles every bit
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
         end
         2: begin
            // near gray: low saturation around the gray/black thresholds
            base     = $urandom_range(0, 255);
            px.red   = clamp_channel(base + $urandom_range(0, 16) - 8);
            px.green = clamp_channel(base + $urandom_range(0, 16) - 8);
            px.blue  = clamp_channel(base + $urandom_range(0, 16) - 8);
         end
         3: begin
            // dark pixels for the black class and small spans
            px.red   = 8'($urandom_range(0, 40));
            px.green = 8'($urandom_range(0, 40));
            px.blue  = 8'($urandom_range(0, 40));
         end
         4: begin
            // strongly saturated, sweeps hue across every sector
            hi  = 8'($urandom_range(128, 255));
            lo  = 8'($urandom_range(0, 40));
            mid = 8'($urandom_range(int'(lo), int'(hi)));
            case ($urandom_range(0, 5))
               0: px = '{hi, mid, lo};
               1: px = '{hi, lo, mid};
               2: px = '{mid, hi, lo};
               3: px = '{lo, hi, mid};
               4: px = '{mid, lo, hi};
               default: px = '{lo, mid, hi};
            endcase
         end
         default: begin
            // two channels equal, exercises the max/min tie order
            hi  = 8'($urandom);
            mid = 8'($urandom);
            case ($urandom_range(0, 2))
               0: px = '{hi, hi, mid};
               1: px = '{hi, mid, hi};
               default: px = '{mid, hi, hi};
            endcase
         end
      endcase
      return px;
   endfunction

   initial begin
      int pause_at;
      reset       = 1'b1;
      start       = 1'b0;
      req_pixel   = '0;
      pixels_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      drive_pixel('{8'd0, 8'd0, 8'd0});         // black pixel, value 0
      drive_pixel('{8'd255, 8'd255, 8'd255});   // white, gray class
      drive_pixel('{8'd128, 8'd128, 8'd128});   // mid gray, max equals min
      drive_pixel('{8'd20, 8'd18, 8'd22});      // dark, too saturated for black class
      drive_pixel('{8'd1, 8'd0, 8'd0});         // smallest nonzero value
      drive_pixel('{8'd255, 8'd0, 8'd0});       // pure red
      drive_pixel('{8'd0, 8'd255, 8'd0});       // pure green
      drive_pixel('{8'd0, 8'd0, 8'd255});       // pure blue
      drive_pixel('{8'd255, 8'd255, 8'd0});     // yellow, red/green tie
      drive_pixel('{8'd0, 8'd255, 8'd255});     // cyan, green/blue tie
      drive_pixel('{8'd255, 8'd0, 8'd255});     // magenta, red/blue tie
      drive_pixel('{8'd200, 8'd200, 8'd50});    // red wins a tie with green
      drive_pixel('{8'd10, 8'd200, 8'd200});    // green wins a tie with blue
      drive_pixel('{8'd200, 8'd10, 8'd200});    // red wins a tie with blue
      drive_pixel('{8'd255, 8'd0, 8'd10});      // red max, negative offset wraps
      drive_pixel('{8'd255, 8'd0, 8'd1});       // smallest negative offset, truncates to hue 0
      drive_pixel('{8'd255, 8'd1, 8'd0});       // smallest positive red offset, truncates to hue 0
      drive_pixel('{8'd254, 8'd255, 8'd255});   // tiny span at full value
      drive_pixel('{8'd1, 8'd1, 8'd0});         // tiny dark yellow
      drive_pixel('{8'd255, 8'd170, 8'd0});     // orange, red/yellow border
      drive_pixel('{8'd0, 8'd128, 8'd255});     // azure, inside blue class
      drive_pixel('{8'd170, 8'd0, 8'd255});     // violet, past blue class high edge, no class
      drive_pixel('{8'd128, 8'd255, 8'd0});     // chartreuse, green/yellow border
      drive_pixel('{8'd140, 8'd120, 8'd120});   // faint red, gray threshold region

      // random part; one point mid-run waits for the pipeline to empty
      pause_at = $urandom_range(500, 900);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == pause_at)
            wait_pipeline_empty();
         // idle bursts, except in a clean window and the final stretch
         if (i < RANDOM_PIXELS - QUIET_TAIL && !(i >= 300 && i < 420) &&
             $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 5));
         drive_pixel(random_pixel());
      end

      // drain: wait for the last transactions, then let the pipe settle
      wait_pipeline_empty();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run summary: %0d pixels sent, %0d hsv transactions checked",
               pixels_sent, results_checked);
      $display("covered black/gray/pure/tie/wrap corners plus near-gray, dark, saturated mixes");
      if (mismatch_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
